// ----- rtl/core/mcps_pkg.sv -----
package mcps_pkg;

    localparam int LANES       = 4;
    localparam int FACTOR_W    = 8;
    localparam int WEIGHT_W    = 16;
    localparam int SCORE_W     = 40;
    localparam int PROD_W      = 24;   // weight times byte
    localparam int OWA_W       = 44;   // order weight times product, plus carries
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;

    localparam logic [1:0] MODE_BOOL = 2'd0;
    localparam logic [1:0] MODE_WLC  = 2'd1;
    localparam logic [1:0] MODE_OWA  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NFACT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NCONS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FWEIGHTS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OWEIGHTS = 3'd4;

    // Classified pixel handed from the front end to the back end.
    typedef struct packed {
        logic                             zero;
        logic [1:0]                       mode;
        logic [2:0]                       nf;
        logic [LANES-1:0][PROD_W-1:0]     prod;   // weighted lanes, unused lanes zero
        logic [LANES-1:0][FACTOR_W-1:0]   fac;    // raw bytes, unused lanes one
    } work_t;

endpackage

// ----- rtl/core/mcps_front.sv -----
module mcps_front
    import mcps_pkg::*;
#(
    parameter int MAX_FACTORS      = 4,
    parameter int MAX_CONSTRAINTS  = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [FACTOR_W-1:0]           factor_a,
    input  logic [FACTOR_W-1:0]           factor_b,
    input  logic [FACTOR_W-1:0]           factor_c,
    input  logic [FACTOR_W-1:0]           factor_d,
    input  logic [3:0]                    constraint_bits,
    input  logic [1:0]                    eval_mode,
    input  logic [2:0]                    factors_in_use,
    input  logic [2:0]                    constraints_in_use,
    input  logic [CFG_W-1:0]              factor_weight_words,
    output logic                          q_valid,
    input  logic                          q_stall,
    output work_t                         q_work
);

    localparam int FLIM = (MAX_FACTORS < LANES) ? MAX_FACTORS : LANES;
    localparam int CLIM = (MAX_CONSTRAINTS < LANES) ? MAX_CONSTRAINTS : LANES;

    logic [2:0]              nf;
    logic [2:0]              nc;
    logic [LANES-1:0]        cmask;
    logic [LANES-1:0][7:0]   x;
    work_t                   w;
    work_t                   stage_reg;
    logic                    valid_reg;
    logic                    take;

    assign nf = (factors_in_use > 3'(FLIM)) ? 3'(FLIM) : factors_in_use;
    assign nc = (constraints_in_use > 3'(CLIM)) ? 3'(CLIM) : constraints_in_use;
    assign x  = {factor_d, factor_c, factor_b, factor_a};

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            cmask[i] = (3'(i) < nc);
        end
        w.zero = ((constraint_bits & cmask) != cmask);
        w.mode = eval_mode;
        w.nf   = nf;
        for (int i = 0; i < LANES; i++)
        begin
            if (3'(i) < nf)
            begin
                w.prod[i] = PROD_W'(factor_weight_words[i*WEIGHT_W +: WEIGHT_W]) * PROD_W'(x[i]);
                w.fac[i]  = x[i];
            end
            else
            begin
                w.prod[i] = '0;
                w.fac[i]  = 8'd1;
            end
        end
    end

    assign in_stall = valid_reg && q_stall;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg <= w;
        end
    end

    assign q_valid = valid_reg;
    assign q_work  = stage_reg;

endmodule

// ----- rtl/core/mcps_queue.sv -----
module mcps_queue
    import mcps_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  work_t  in_work,
    output logic   out_valid,
    input  logic   out_stall,
    output work_t  out_work
);

    // Two-entry queue; full only when both slots hold beats.
    work_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    logic        pop;

    assign in_stall  = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_work  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_work;
        end
    end

endmodule

// ----- rtl/core/mcps_back.sv -----
module mcps_back
    import mcps_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = 15
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  work_t               in_work,
    input  logic [CFG_W-1:0]    order_weight_words,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SCORE_W-1:0]  score
);

    localparam int WLC_SH = WEIGHT_FRAC_BITS - 8;
    localparam int OWA_SH = 2 * WEIGHT_FRAC_BITS - 8;

    // Stage 1: sorting network, two byte products and the WLC sum.
    // Stage 2: order-weight products and remaining Boolean product.
    // Stage 3: sum, scale by count, shift and saturate.
    typedef struct packed {
        logic                         zero;
        logic [1:0]                   mode;
        logic [2:0]                   nf;
        logic [LANES-1:0][PROD_W-1:0] sorted;
        logic [15:0]                  p01;
        logic [15:0]                  p23;
        logic [PROD_W+1:0]            wsum;
    } s1_t;

    typedef struct packed {
        logic                         zero;
        logic [1:0]                   mode;
        logic [2:0]                   nf;
        logic [LANES-1:0][OWA_W-1:0]  owa;
        logic [31:0]                  bprod;
        logic [PROD_W+1:0]            wsum;
    } s2_t;

    s1_t             s1_next;
    s1_t             s1_reg;
    s2_t             s2_next;
    s2_t             s2_reg;
    logic [2:0]      v_reg;
    logic [2:0]      adv;
    logic [SCORE_W-1:0] score_next;
    logic [SCORE_W-1:0] score_reg;
    logic [LANES-1:0][PROD_W-1:0] srt;
    logic [PROD_W-1:0] tmp;
    logic [OWA_W+1:0] osum;
    logic [OWA_W+4:0] oscaled;
    logic [63:0]      bshift;
    logic [63:0]      res;

    // Stall moves back from the output register through each stage.
    assign adv[2]   = !v_reg[2] || !out_stall;
    assign adv[1]   = !v_reg[1] || adv[2];
    assign adv[0]   = !v_reg[0] || adv[1];
    assign in_stall = !adv[0];

    always_comb
    begin
        srt = in_work.prod;
        tmp = '0;
        // Five compare-exchanges sort four values ascending; unused lanes are
        // zero and land in the low ranks, so the live ones are moved down below.
        for (int k = 0; k < 5; k++)
        begin
            int a;
            int b;
            a = (k == 0) ? 0 : (k == 1) ? 2 : (k == 2) ? 0 : (k == 3) ? 1 : 1;
            b = (k == 0) ? 1 : (k == 1) ? 3 : (k == 2) ? 2 : (k == 3) ? 3 : 2;
            if (srt[a] > srt[b])
            begin
                tmp    = srt[a];
                srt[a] = srt[b];
                srt[b] = tmp;
            end
        end
        s1_next.zero = in_work.zero;
        s1_next.mode = in_work.mode;
        s1_next.nf   = in_work.nf;
        // Rank r of the live lanes sits at sorted index r + (LANES - nf).
        for (int r = 0; r < LANES; r++)
        begin
            s1_next.sorted[r] = (3'(r) < in_work.nf) ?
                srt[2'(3'(r) + 3'(LANES) - in_work.nf)] : '0;
        end
        s1_next.p01  = 16'(in_work.fac[0]) * 16'(in_work.fac[1]);
        s1_next.p23  = 16'(in_work.fac[2]) * 16'(in_work.fac[3]);
        s1_next.wsum = (PROD_W+2)'(in_work.prod[0]) + (PROD_W+2)'(in_work.prod[1])
                     + (PROD_W+2)'(in_work.prod[2]) + (PROD_W+2)'(in_work.prod[3]);
    end

    always_comb
    begin
        s2_next.zero  = s1_reg.zero;
        s2_next.mode  = s1_reg.mode;
        s2_next.nf    = s1_reg.nf;
        s2_next.wsum  = s1_reg.wsum;
        s2_next.bprod = 32'(s1_reg.p01) * 32'(s1_reg.p23);
        for (int r = 0; r < LANES; r++)
        begin
            s2_next.owa[r] = OWA_W'(order_weight_words[r*WEIGHT_W +: WEIGHT_W])
                           * OWA_W'(s1_reg.sorted[r]);
        end
    end

    always_comb
    begin
        osum    = (OWA_W+2)'(s2_reg.owa[0]) + (OWA_W+2)'(s2_reg.owa[1])
                + (OWA_W+2)'(s2_reg.owa[2]) + (OWA_W+2)'(s2_reg.owa[3]);
        // The count is at most four, so the scaling is a shift-and-add.
        oscaled = (s2_reg.nf[0] ? (OWA_W+5)'(osum) : '0)
                + (s2_reg.nf[1] ? ((OWA_W+5)'(osum) << 1) : '0)
                + (s2_reg.nf[2] ? ((OWA_W+5)'(osum) << 2) : '0);
        bshift  = {24'd0, s2_reg.bprod, 8'd0};
        res     = '0;
        case (s2_reg.mode)
            MODE_BOOL: res = bshift;
            MODE_WLC:  res = 64'(s2_reg.wsum >> WLC_SH);
            MODE_OWA:  res = 64'(oscaled >> OWA_SH);
            default:   res = '0;
        endcase
        if (s2_reg.zero)
        begin
            score_next = '0;
        end
        else if (res > 64'({SCORE_W{1'b1}}))
        begin
            score_next = '1;
        end
        else
        begin
            score_next = res[SCORE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 3'b000;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (adv[2])
            begin
                v_reg[2] <= v_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (adv[1] && v_reg[0])
        begin
            s2_reg <= s2_next;
        end
        if (adv[2] && v_reg[1])
        begin
            score_reg <= score_next;
        end
    end

    assign out_valid = v_reg[2];
    assign score     = score_reg;

endmodule

// ----- rtl/core/multi_criteria_pixel_score.sv -----
// An accepted input beat passes the front register, the queue and three
// back-end stages to its score beat, waiting longer while the output stalls.
// Throughput: one pixel per cycle without stalls; the front end accepts while
// its register is empty or the queue has room. Reset (rst_n low, asynchronous)
// empties all stages; loads mode WLC, four factors, no constraints, zero weights.
module multi_criteria_pixel_score
    import mcps_pkg::*;
#(
    parameter int MAX_FACTORS      = 4,
    parameter int MAX_CONSTRAINTS  = 4,
    parameter int WEIGHT_FRAC_BITS = 15
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [FACTOR_W-1:0]   factor_a,
    input  logic [FACTOR_W-1:0]   factor_b,
    input  logic [FACTOR_W-1:0]   factor_c,
    input  logic [FACTOR_W-1:0]   factor_d,
    input  logic [3:0]            constraint_bits,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SCORE_W-1:0]    score
);

    logic [1:0]        mode_reg;
    logic [2:0]        nf_reg;
    logic [2:0]        nc_reg;
    logic [CFG_W-1:0]  fw_reg;
    logic [CFG_W-1:0]  ow_reg;
    logic              f_valid;
    logic              f_stall;
    work_t             f_work;
    logic              b_valid;
    logic              b_stall;
    work_t             b_work;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_WLC;
            nf_reg   <= 3'd4;
            nc_reg   <= 3'd0;
            fw_reg   <= '0;
            ow_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:     mode_reg <= cfg_data[1:0];
                REG_NFACT:    nf_reg   <= cfg_data[2:0];
                REG_NCONS:    nc_reg   <= cfg_data[2:0];
                REG_FWEIGHTS: fw_reg   <= cfg_data;
                REG_OWEIGHTS: ow_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    mcps_front #(
        .MAX_FACTORS     (MAX_FACTORS),
        .MAX_CONSTRAINTS (MAX_CONSTRAINTS)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .factor_a            (factor_a),
        .factor_b            (factor_b),
        .factor_c            (factor_c),
        .factor_d            (factor_d),
        .constraint_bits     (constraint_bits),
        .eval_mode           (mode_reg),
        .factors_in_use      (nf_reg),
        .constraints_in_use  (nc_reg),
        .factor_weight_words (fw_reg),
        .q_valid             (f_valid),
        .q_stall             (f_stall),
        .q_work              (f_work)
    );

    mcps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_stall  (f_stall),
        .in_work   (f_work),
        .out_valid (b_valid),
        .out_stall (b_stall),
        .out_work  (b_work)
    );

    mcps_back #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (b_valid),
        .in_stall           (b_stall),
        .in_work            (b_work),
        .order_weight_words (ow_reg),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .score              (score)
    );

endmodule
